@@ rtl/todc_pkg.sv @@
// types and constants shared by the time-of-day clock with switching windows
package todc_pkg;

  // field widths
  localparam int unsigned HOUR_W     = 5;
  localparam int unsigned MIN_W      = 6;
  localparam int unsigned SEC_W      = 6;
  localparam int unsigned DIV_W      = 8;
  localparam int unsigned TIME_W     = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned MAX_WIN    = 3;

  // time limits
  localparam logic [HOUR_W-1:0] HOUR_MAX = 5'd23;
  localparam logic [MIN_W-1:0]  MIN_MAX  = 6'd59;
  localparam logic [SEC_W-1:0]  SEC_MAX  = 6'd59;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICK_DIVIDE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_BASE    = 3'd1;

  // reset values
  localparam logic [DIV_W-1:0] TICK_DIVIDE_RESET = 8'd2;
  localparam logic [MAX_WIN-1:0][TIME_W-1:0] WIN_START_RESET = {17'd448, 17'd256, 17'd64};
  localparam logic [MAX_WIN-1:0][TIME_W-1:0] WIN_END_RESET   = {17'd576, 17'd384, 17'd192};

  // operation codes
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  // input transaction
  typedef struct packed {
    op_t               operation;
    logic [HOUR_W-1:0] load_hour;
    logic [MIN_W-1:0]  load_minute;
    logic [SEC_W-1:0]  load_second;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic              switch_level;
  } out_t;

  // clock state carried between transactions
  typedef struct packed {
    logic [DIV_W-1:0]  prescale;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic              level;
  } state_t;

endpackage

@@ rtl/time_of_day_clock_alarm_windows_top.sv @@
// top level: config registers, clock state and registered result
// the output register holds the result of an accepted transaction from the following cycle
// throughput: one transaction per cycle while not stalled; the state update is a single pass of todc_step
// input stalls only while a held result is itself stalled
// reset (rst, synchronous): time 00:00:00, prescale 0, level low, output empty,
// tick_divide 2 and windows 0:01:00-0:03:00, 0:04:00-0:06:00, 0:07:00-0:09:00
module time_of_day_clock_alarm_windows_top import todc_pkg::*; #(
  parameter int unsigned NUM_WINDOWS = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data
);

  logic [DIV_W-1:0]                   tick_divide;
  logic [NUM_WINDOWS-1:0][TIME_W-1:0] win_start;
  logic [NUM_WINDOWS-1:0][TIME_W-1:0] win_end;
  state_t                             state;
  state_t                             state_next;
  logic                               in_take;

  // divide register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_divide <= TICK_DIVIDE_RESET;
    end else if (cfg_wr_en && cfg_index == REG_TICK_DIVIDE) begin
      tick_divide <= cfg_data[DIV_W-1:0];
    end
  end

  // window registers, start and end of each window at consecutive indexes
  for (genvar w = 0; w < NUM_WINDOWS; w++) begin : g_win
    localparam logic [CFG_IDX_W-1:0] START_IDX = REG_WIN_BASE + CFG_IDX_W'(2 * w);
    localparam logic [CFG_IDX_W-1:0] END_IDX   = START_IDX + CFG_IDX_W'(1);
    always_ff @(posedge clk) begin
      if (rst) begin
        win_start[w] <= WIN_START_RESET[w];
        win_end[w]   <= WIN_END_RESET[w];
      end else if (cfg_wr_en) begin
        if (cfg_index == START_IDX) win_start[w] <= cfg_data[TIME_W-1:0];
        if (cfg_index == END_IDX)   win_end[w]   <= cfg_data[TIME_W-1:0];
      end
    end
  end

  // handshake
  assign in_stall = out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  todc_step #(
    .NUM_WINDOWS (NUM_WINDOWS)
  ) u_step (
    .cur         (state),
    .item        (in_data),
    .tick_divide (tick_divide),
    .win_start   (win_start),
    .win_end     (win_end),
    .nxt         (state_next)
  );

  // clock state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_take) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_data.hour         <= state_next.hour;
      out_data.minute       <= state_next.minute;
      out_data.second       <= state_next.second;
      out_data.switch_level <= state_next.level;
    end
  end

endmodule

@@ rtl/todc_step.sv @@
// next-state logic: prescaler, time advance, load saturation and window compare
module todc_step import todc_pkg::*; #(
  parameter int unsigned NUM_WINDOWS = 3
) (
  input  state_t                                cur,
  input  in_t                                   item,
  input  logic [DIV_W-1:0]                      tick_divide,
  input  logic [NUM_WINDOWS-1:0][TIME_W-1:0]    win_start,
  input  logic [NUM_WINDOWS-1:0][TIME_W-1:0]    win_end,
  output state_t                                nxt
);

  logic [DIV_W-1:0]  pre_inc;
  logic              sec_step;
  logic              sec_wrap;
  logic              min_wrap;
  logic [HOUR_W-1:0] hour_adv;
  logic [MIN_W-1:0]  min_adv;
  logic [SEC_W-1:0]  sec_adv;
  logic [TIME_W-1:0] now;
  logic              lvl;

  // prescaler and carry chain through seconds, minutes, hours
  always_comb begin
    pre_inc  = cur.prescale + DIV_W'(1);
    sec_step = (pre_inc >= tick_divide);
    sec_wrap = (cur.second >= SEC_MAX);
    min_wrap = (cur.minute >= MIN_MAX);
    sec_adv  = cur.second;
    min_adv  = cur.minute;
    hour_adv = cur.hour;
    if (sec_step) begin
      sec_adv = sec_wrap ? '0 : cur.second + SEC_W'(1);
      if (sec_wrap) begin
        min_adv = min_wrap ? '0 : cur.minute + MIN_W'(1);
        if (min_wrap) begin
          hour_adv = (cur.hour >= HOUR_MAX) ? '0 : cur.hour + HOUR_W'(1);
        end
      end
    end
  end

  // window compare, later matches override earlier ones
  always_comb begin
    now = {hour_adv, min_adv, sec_adv};
    lvl = cur.level;
    for (int w = 0; w < NUM_WINDOWS; w++) begin
      if (now == win_start[w]) lvl = 1'b1;
      if (now == win_end[w])   lvl = 1'b0;
    end
  end

  // select between load and tick
  always_comb begin
    nxt = cur;
    unique case (item.operation)
      OP_LOAD: begin
        nxt.hour   = (item.load_hour > HOUR_MAX)  ? HOUR_MAX : item.load_hour;
        nxt.minute = (item.load_minute > MIN_MAX) ? MIN_MAX  : item.load_minute;
        nxt.second = (item.load_second > SEC_MAX) ? SEC_MAX  : item.load_second;
      end
      OP_TICK: begin
        nxt.prescale = sec_step ? '0 : pre_inc;
        nxt.hour     = hour_adv;
        nxt.minute   = min_adv;
        nxt.second   = sec_adv;
        nxt.level    = lvl;
      end
      default: nxt = cur;
    endcase
  end

endmodule

@@ rtl/todc_checker.sv @@
// port-level checks for the time-of-day clock, bound to the top level
module todc_checker import todc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // held result stays put while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // every accepted transaction shows a result in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("no result after accepted transaction");

  // time fields stay in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.hour <= HOUR_MAX && out_data.minute <= MIN_MAX
                  && out_data.second <= SEC_MAX)
    else $error("time out of range");

  // load transaction gives saturated load time
  a_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.operation == OP_LOAD |=>
      out_data.hour == (($past(in_data.load_hour) > HOUR_MAX) ? HOUR_MAX
                        : $past(in_data.load_hour)) &&
      out_data.minute == (($past(in_data.load_minute) > MIN_MAX) ? MIN_MAX
                          : $past(in_data.load_minute)) &&
      out_data.second == (($past(in_data.load_second) > SEC_MAX) ? SEC_MAX
                          : $past(in_data.load_second)))
    else $error("load result mismatch");

endmodule

bind time_of_day_clock_alarm_windows_top todc_checker u_todc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
